### sv/qsts_pkg.sv
// Package for the quaternion swing/twist split: payload types, fixed-point
// constants and the rounding/saturation helpers shared by the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qsts_pkg;

	localparam int FRAC_BITS_DEF = 30;
	localparam int LANES         = 4;
	localparam int SQRT_STAGES   = 32;
	localparam int DIV_STAGES    = 32;

	typedef logic [LANES-1:0][31:0] vec4_t;

	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
		logic signed [31:0] rot_w;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] swing_x;
		logic signed [31:0] swing_y;
		logic signed [31:0] swing_z;
		logic signed [31:0] swing_w;
		logic signed [31:0] twist_x;
		logic signed [31:0] twist_y;
		logic signed [31:0] twist_z;
		logic signed [31:0] twist_w;
		logic               degenerate;
	} result_t;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	// Shift right by frac with rounding half away from zero, then saturate.
	function automatic logic [31:0] rescale(input logic signed [67:0] v, input int frac);
		logic [67:0] m;
		logic [67:0] r;
		logic [31:0] res;
		m = v[67] ? 68'(-v) : 68'(v);
		r = (m + (68'd1 << (frac - 1))) >> frac;
		if (v[67]) begin
			if (r > 68'h8000_0000) res = S32_MIN;
			else                   res = 32'(-r);
		end else begin
			if (r > 68'h7fff_ffff) res = S32_MAX;
			else                   res = r[31:0];
		end
		return res;
	endfunction

	// Negate with saturation: the most negative value maps to the maximum.
	function automatic logic [31:0] neg_sat(input logic [31:0] x);
		logic [31:0] res;
		if (x == S32_MIN) res = S32_MAX;
		else              res = 32'(-x);
		return res;
	endfunction

endpackage

`default_nettype wire

### sv/qsts_item_if.sv
// Input channel: valid/ready handshake carrying one rotation and twist axis.
// Depends on qsts_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface qsts_item_if;
	logic                valid;
	logic                ready;
	qsts_pkg::item_t     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/qsts_result_if.sv
// Output channel: valid/ready handshake carrying swing, twist and flag.
// Depends on qsts_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface qsts_result_if;
	logic                valid;
	logic                ready;
	qsts_pkg::result_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/qsts_norm.sv
// Pipelined 4-vector normalizer: squares, sum, bit-pair integer square root
// (one result bit per stage) and four restoring dividers (one quotient bit per
// stage). Depends on qsts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsts_norm #(
	parameter int FRAC_BITS = qsts_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W    = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_v,
	input  wire qsts_pkg::vec4_t       in_vec,
	input  wire logic [SIDE_W-1:0]     in_side,
	output logic                       out_v,
	output qsts_pkg::vec4_t            out_vec,
	output logic                       out_zero,
	output logic [SIDE_W-1:0]          out_side
);

	localparam int N   = qsts_pkg::LANES;
	localparam int SQN = qsts_pkg::SQRT_STAGES;
	localparam int DVN = qsts_pkg::DIV_STAGES;
	localparam int CW  = SIDE_W + 32 * N + N;
	localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

	// squares
	logic [N-1:0][31:0] mag;
	logic [N-1:0]       neg;
	logic [63:0]        sq_s1 [N];
	logic [CW-1:0]      car_s1;
	logic               v_s1;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			neg[i] = in_vec[i][31];
			mag[i] = neg[i] ? 32'(-in_vec[i]) : in_vec[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) sq_s1[i] <= 64'(mag[i]) * 64'(mag[i]);
			car_s1 <= {in_side, mag, neg};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	// sum of squares, saturated to 64 bits; feeds the root stages
	logic [63:0]   sqn_s [0:SQN];
	logic [63:0]   sqr_s [0:SQN];
	logic [CW-1:0] sqc_s [0:SQN];
	logic          sqv_s [0:SQN];
	logic [65:0]   acc;

	assign acc = 66'(sq_s1[0]) + 66'(sq_s1[1]) + 66'(sq_s1[2]) + 66'(sq_s1[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			sqn_s[0] <= (acc[65:64] != 2'b00) ? 64'hffff_ffff_ffff_ffff : acc[63:0];
			sqr_s[0] <= 64'd0;
			sqc_s[0] <= car_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s[0] <= 1'b0;
		end else if (en) begin
			sqv_s[0] <= v_s1;
		end
	end

	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		logic        take;

		assign trial = sqr_s[k] + BITV;
		assign take  = sqn_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sqn_s[k+1] <= take ? sqn_s[k] - trial : sqn_s[k];
				sqr_s[k+1] <= take ? (sqr_s[k] >> 1) + BITV : sqr_s[k] >> 1;
				sqc_s[k+1] <= sqc_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k+1] <= 1'b0;
			end else if (en) begin
				sqv_s[k+1] <= sqv_s[k];
			end
		end
	end

	// dividend setup and overflow check, then the divider stages
	logic [63:0]       drem_s [0:DVN][N];
	logic [31:0]       dquo_s [0:DVN][N];
	logic [31:0]       dlen_s [0:DVN];
	logic [N-1:0]      dovf_s [0:DVN];
	logic              dzero_s [0:DVN];
	logic [SIDE_W+N-1:0] dcar_s [0:DVN];
	logic              dv_s [0:DVN];

	logic [31:0] len;
	logic [63:0] dvd [N];
	logic [63:0] lim;

	assign len = sqr_s[SQN][31:0];
	assign lim = {len, 32'd0};

	always_comb begin
		for (int i = 0; i < N; i++) begin
			dvd[i] = (64'(sqc_s[SQN][N + 32*i +: 32]) << FRAC_BITS) + 64'(len >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				drem_s[0][i] <= dvd[i];
				dquo_s[0][i] <= 32'd0;
				dovf_s[0][i] <= dvd[i] >= lim;
			end
			dlen_s[0]  <= len;
			dzero_s[0] <= len == 32'd0;
			dcar_s[0]  <= {sqc_s[SQN][CW-1 -: SIDE_W], sqc_s[SQN][N-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= sqv_s[SQN];
		end
	end

	for (genvar k = 0; k < DVN; k++) begin : g_div
		logic [63:0]  trial;
		logic [N-1:0] take;

		assign trial = 64'(dlen_s[k]) << (DVN - 1 - k);

		always_comb begin
			for (int i = 0; i < N; i++) take[i] = drem_s[k][i] >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < N; i++) begin
					drem_s[k+1][i] <= take[i] ? drem_s[k][i] - trial : drem_s[k][i];
					dquo_s[k+1][i] <= {dquo_s[k][i][30:0], take[i]};
				end
				dlen_s[k+1]  <= dlen_s[k];
				dovf_s[k+1]  <= dovf_s[k];
				dzero_s[k+1] <= dzero_s[k];
				dcar_s[k+1]  <= dcar_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_s[k+1] <= dv_s[k];
			end
		end
	end

	// sign, saturation and the zero-length identity
	qsts_pkg::vec4_t res;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (dzero_s[DVN]) begin
				res[i] = (i == N - 1) ? ONE_FX : 32'd0;
			end else if (dovf_s[DVN][i] || dquo_s[DVN][i][31]) begin
				res[i] = dcar_s[DVN][i] ? qsts_pkg::S32_MIN : qsts_pkg::S32_MAX;
			end else begin
				res[i] = dcar_s[DVN][i] ? 32'(-dquo_s[DVN][i]) : dquo_s[DVN][i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec  <= res;
			out_zero <= dzero_s[DVN];
			out_side <= dcar_s[DVN][SIDE_W+N-1 -: SIDE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= dv_s[DVN];
		end
	end

endmodule

`default_nettype wire

### sv/qsts_skid.sv
// Output register plus one skid entry; frees the pipeline from the
// result-side ready. Depends on qsts_pkg and qsts_result_if.
`timescale 1ns / 1ps
`default_nettype none

module qsts_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_v,
	input  wire qsts_pkg::result_t push_data,
	output logic                   en,
	qsts_result_if.source          result
);

	logic              out_v_q;
	logic              skid_v_q;
	qsts_pkg::result_t out_q;
	qsts_pkg::result_t skid_q;
	logic              pop;
	logic              push;
	logic              free;

	assign en   = !skid_v_q;
	assign pop  = out_v_q && result.ready;
	assign push = en && push_v;
	assign free = pop || !out_v_q;

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (free) out_v_q <= skid_v_q || push;
			if (skid_v_q) begin
				if (free) skid_v_q <= 1'b0;
			end else if (push && !free) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free) out_q <= skid_v_q ? skid_q : push_data;
		if (!skid_v_q && push && !free) skid_q <= push_data;
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !result.ready))
		else $error("skid entry filled without an output stall");

endmodule

`default_nettype wire

### sv/quaternion_swing_twist_split.sv
// Top level of the swing/twist split pipeline.
// Depends on qsts_pkg, qsts_item_if, qsts_result_if, qsts_norm, qsts_skid.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    rot_x..rot_w, axis_x..axis_z (Q2.30)
//   result   out  valid/ready    swing_x..w, twist_x..w, degenerate
//
// One request per cycle sustained while no result stall holds the pipeline; most
// of the depth lies in the two normalizers (32 square-root stages and 32
// divider stages each). Reset clears only valid bits. A result stall parks
// one item in the skid entry; the whole pipeline then holds until it drains.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_swing_twist_split #(
	parameter int FRAC_BITS = qsts_pkg::FRAC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	qsts_item_if.sink      item,
	qsts_result_if.source  result
);

	localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

	logic en;

	assign item.ready = en;

	// input register
	qsts_pkg::item_t in_s1;
	logic            v_s1;

	always_ff @(posedge clk) begin
		if (en) in_s1 <= item.data;
	end

	// rotation normalize
	qsts_pkg::vec4_t rot_vec;
	qsts_pkg::vec4_t qn;
	logic [95:0]     qn_axis;
	logic            qn_v;

	assign rot_vec = {in_s1.rot_w, in_s1.rot_z, in_s1.rot_y, in_s1.rot_x};

	qsts_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(96)) u_norm_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s1),
		.in_vec   (rot_vec),
		.in_side  ({in_s1.axis_z, in_s1.axis_y, in_s1.axis_x}),
		.out_v    (qn_v),
		.out_vec  (qn),
		.out_zero (),
		.out_side (qn_axis)
	);

	// s2: flip to nonnegative w
	qsts_pkg::vec4_t  q_s2, q_s3, q_s4, q_s5, q_s6, q_s7;
	logic [2:0][31:0] a_s2, a_s3, a_s4;
	logic signed [63:0] qa_s3 [3];
	logic [31:0]      dot_s4;
	logic signed [63:0] ap_s5 [3];
	logic             dneg_s5, dneg_s6;
	logic [2:0][31:0] p_s6;
	qsts_pkg::vec4_t  t_s7;
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [67:0] dsum;
	qsts_pkg::vec4_t  t_c;

	assign dsum = 68'(qa_s3[0]) + 68'(qa_s3[1]) + 68'(qa_s3[2]);

	always_comb begin
		t_c = {q_s6[3], p_s6[2], p_s6[1], p_s6[0]};
		if (dneg_s6 && (p_s6 != '0)) begin
			for (int i = 0; i < 4; i++) t_c[i] = qsts_pkg::neg_sat(t_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				q_s2[i] <= qn[3][31] ? qsts_pkg::neg_sat(qn[i]) : qn[i];
			end
			a_s2 <= qn_axis;

			for (int i = 0; i < 3; i++) qa_s3[i] <= $signed(q_s2[i]) * $signed(a_s2[i]);
			q_s3 <= q_s2;
			a_s3 <= a_s2;

			dot_s4 <= qsts_pkg::rescale(dsum, FRAC_BITS);
			q_s4   <= q_s3;
			a_s4   <= a_s3;

			for (int i = 0; i < 3; i++) ap_s5[i] <= $signed(a_s4[i]) * $signed(dot_s4);
			dneg_s5 <= dot_s4[31];
			q_s5    <= q_s4;

			for (int i = 0; i < 3; i++) p_s6[i] <= qsts_pkg::rescale(68'(ap_s5[i]), FRAC_BITS);
			dneg_s6 <= dneg_s5;
			q_s6    <= q_s5;

			t_s7 <= t_c;
			q_s7 <= q_s6;
		end
	end

	// twist normalize, rotation rides along
	qsts_pkg::vec4_t tn;
	logic [127:0]    tn_q;
	logic            tn_zero;
	logic            tn_v;

	qsts_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(128)) u_norm_twist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s7),
		.in_vec   (t_s7),
		.in_side  (q_s7),
		.out_v    (tn_v),
		.out_vec  (tn),
		.out_zero (tn_zero),
		.out_side (tn_q)
	);

	// s8: rotation times conjugate twist, partial products
	qsts_pkg::vec4_t    qv;
	logic signed [32:0] cj [4];
	logic signed [64:0] pr_s8 [4][4];
	qsts_pkg::vec4_t    tn_s8, tn_s9, tn_s10;
	logic               z_s8, z_s9, z_s10;
	logic signed [66:0] sum_s9 [4];
	logic [31:0]        sw_s10 [4];
	logic v_s8, v_s9, v_s10;

	assign qv = tn_q;

	always_comb begin
		for (int k = 0; k < 3; k++) cj[k] = -33'($signed(tn[k]));
		cj[3] = 33'($signed(tn[3]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 4; k++) pr_s8[j][k] <= $signed(qv[j]) * cj[k];
			end
			tn_s8 <= tn;
			z_s8  <= tn_zero;

			sum_s9[0] <= 67'(pr_s8[3][0]) + 67'(pr_s8[0][3]) + 67'(pr_s8[1][2])
				- 67'(pr_s8[2][1]);
			sum_s9[1] <= 67'(pr_s8[3][1]) + 67'(pr_s8[1][3]) + 67'(pr_s8[2][0])
				- 67'(pr_s8[0][2]);
			sum_s9[2] <= 67'(pr_s8[3][2]) + 67'(pr_s8[2][3]) + 67'(pr_s8[0][1])
				- 67'(pr_s8[1][0]);
			sum_s9[3] <= 67'(pr_s8[3][3]) - 67'(pr_s8[0][0]) - 67'(pr_s8[1][1])
				- 67'(pr_s8[2][2]);
			tn_s9 <= tn_s8;
			z_s9  <= z_s8;

			for (int i = 0; i < 4; i++) sw_s10[i] <= qsts_pkg::rescale(68'(sum_s9[i]), FRAC_BITS);
			tn_s10 <= tn_s9;
			z_s10  <= z_s9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= item.valid;
			v_s2  <= qn_v;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= tn_v;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	qsts_pkg::result_t res_d;

	always_comb begin
		res_d.swing_x    = sw_s10[0];
		res_d.swing_y    = sw_s10[1];
		res_d.swing_z    = sw_s10[2];
		res_d.swing_w    = sw_s10[3];
		res_d.twist_x    = tn_s10[0];
		res_d.twist_y    = tn_s10[1];
		res_d.twist_z    = tn_s10[2];
		res_d.twist_w    = tn_s10[3];
		res_d.degenerate = z_s10;
	end

	qsts_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_v    (v_s10),
		.push_data (res_d),
		.en        (en),
		.result    (result)
	);

	a_degenerate_identity: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.degenerate |->
			result.data.twist_x == 32'sd0 && result.data.twist_y == 32'sd0 &&
			result.data.twist_z == 32'sd0 && result.data.twist_w == $signed(ONE_FX))
		else $error("degenerate result without identity twist");

endmodule

`default_nettype wire

### tb/sv/quaternion_swing_twist_split_tb.sv
// Testbench for the swing/twist split: drives rotations and axes through the
// item channel and checks every result against a predictor of its own.
// Depends on qsts_pkg, qsts_item_if, qsts_result_if and the top level.
`timescale 1ns / 1ps

module quaternion_swing_twist_split_tb;

	localparam int FB = 30;
	localparam longint ONE = longint'(1) << FB;
	localparam int DRAIN_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit idle_enable = 1'b1;
	bit mismatch_seen = 1'b0;
	qsts_pkg::result_t pending_results[$];

	qsts_item_if item_ch();
	qsts_result_if result_ch();

	quaternion_swing_twist_split #(.FRAC_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	always #2 clk = ~clk;

	initial begin
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint shift_round(longint v);
		logic [63:0] m;
		logic [63:0] r;
		longint s;
		m = (v < 0) ? 64'(-v) : 64'(v);
		r = (m + (64'd1 << (FB - 1))) >> FB;
		s = longint'(r);
		return clamp32((v < 0) ? -s : s);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Unit-length a 4-vector; returns 1 and the identity when it has no length.
	function automatic bit unit4(input longint v[4], output longint o[4]);
		logic [63:0] acc;
		logic [63:0] m;
		logic [63:0] sq;
		logic [63:0] len;
		logic [63:0] num;
		longint q;
		acc = 0;
		for (int i = 0; i < 4; i++) begin
			m = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
			sq = m * m;
			if (acc > ~64'd0 - sq) acc = ~64'd0;
			else acc = acc + sq;
		end
		len = root_floor(acc);
		if (len == 0) begin
			o = '{0, 0, 0, ONE};
			return 1'b1;
		end
		for (int i = 0; i < 4; i++) begin
			m = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
			num = m << FB;
			q = longint'((num + len / 2) / len);
			o[i] = clamp32((v[i] < 0) ? -q : q);
		end
		return 1'b0;
	endfunction

	function automatic qsts_pkg::result_t split_swing_twist(qsts_pkg::item_t it);
		longint r[4], q[4], a[3], t[4], tn[4], c[4], p[3];
		longint dot;
		bit any_p;
		bit zero_t;
		qsts_pkg::result_t res;
		r = '{it.rot_x, it.rot_y, it.rot_z, it.rot_w};
		a = '{it.axis_x, it.axis_y, it.axis_z};
		void'(unit4(r, q));
		if (q[3] < 0)
			for (int i = 0; i < 4; i++) q[i] = clamp32(-q[i]);
		dot = shift_round(q[0] * a[0] + q[1] * a[1] + q[2] * a[2]);
		any_p = 1'b0;
		for (int i = 0; i < 3; i++) begin
			p[i] = shift_round(a[i] * dot);
			if (p[i] != 0) any_p = 1'b1;
		end
		t = '{p[0], p[1], p[2], q[3]};
		if (dot < 0 && any_p)
			for (int i = 0; i < 4; i++) t[i] = clamp32(-t[i]);
		zero_t = unit4(t, tn);
		c = '{-tn[0], -tn[1], -tn[2], tn[3]};
		res.swing_x = 32'(shift_round(q[3] * c[0] + q[0] * c[3] + q[1] * c[2] - q[2] * c[1]));
		res.swing_y = 32'(shift_round(q[3] * c[1] + q[1] * c[3] + q[2] * c[0] - q[0] * c[2]));
		res.swing_z = 32'(shift_round(q[3] * c[2] + q[2] * c[3] + q[0] * c[1] - q[1] * c[0]));
		res.swing_w = 32'(shift_round(q[3] * c[3] - q[0] * c[0] - q[1] * c[1] - q[2] * c[2]));
		res.twist_x = 32'(tn[0]);
		res.twist_y = 32'(tn[1]);
		res.twist_z = 32'(tn[2]);
		res.twist_w = 32'(tn[3]);
		res.degenerate = zero_t;
		return res;
	endfunction

	function automatic bit idle_now();
		return idle_enable && ($urandom_range(99) < 21);
	endfunction

	// Hold valid across back-to-back requests; drop it only for idle cycles.
	task automatic send_request(qsts_pkg::item_t it);
		if (idle_now()) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
			while (idle_now()) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		pending_results = {pending_results, split_swing_twist(it)};
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// Sink side: random stalls, compare each accepted result to the oldest one.
	always @(posedge clk) begin
		qsts_pkg::result_t want;
		qsts_pkg::result_t got;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (pending_results.size() == 0) begin
					$error("unexpected result %p", got);
					mismatch_seen = 1'b1;
				end else begin
					want = pending_results.pop_front();
					if (got.swing_x !== want.swing_x) begin
						$error("swing_x exp %0d got %0d", want.swing_x, got.swing_x);
						mismatch_seen = 1'b1;
					end
					if (got.swing_y !== want.swing_y) begin
						$error("swing_y exp %0d got %0d", want.swing_y, got.swing_y);
						mismatch_seen = 1'b1;
					end
					if (got.swing_z !== want.swing_z) begin
						$error("swing_z exp %0d got %0d", want.swing_z, got.swing_z);
						mismatch_seen = 1'b1;
					end
					if (got.swing_w !== want.swing_w) begin
						$error("swing_w exp %0d got %0d", want.swing_w, got.swing_w);
						mismatch_seen = 1'b1;
					end
					if (got.twist_x !== want.twist_x) begin
						$error("twist_x exp %0d got %0d", want.twist_x, got.twist_x);
						mismatch_seen = 1'b1;
					end
					if (got.twist_y !== want.twist_y) begin
						$error("twist_y exp %0d got %0d", want.twist_y, got.twist_y);
						mismatch_seen = 1'b1;
					end
					if (got.twist_z !== want.twist_z) begin
						$error("twist_z exp %0d got %0d", want.twist_z, got.twist_z);
						mismatch_seen = 1'b1;
					end
					if (got.twist_w !== want.twist_w) begin
						$error("twist_w exp %0d got %0d", want.twist_w, got.twist_w);
						mismatch_seen = 1'b1;
					end
					if (got.degenerate !== want.degenerate) begin
						$error("degenerate exp %0b got %0b", want.degenerate, got.degenerate);
						mismatch_seen = 1'b1;
					end
				end
			end
			result_ch.ready <= !idle_now();
		end
	end

	function automatic qsts_pkg::item_t make_item(int rx, int ry, int rz, int rw,
		int ax, int ay, int az);
		qsts_pkg::item_t it;
		it.rot_x = rx;
		it.rot_y = ry;
		it.rot_z = rz;
		it.rot_w = rw;
		it.axis_x = ax;
		it.axis_y = ay;
		it.axis_z = az;
		return it;
	endfunction

	task automatic test_directed();
		int one_q;
		int h;
		one_q = 1 << FB;
		h = 759250125; // about 0.7071 in Q2.30
		// identity rotation, and the all-zero rotation treated as identity
		send_request(make_item(0, 0, 0, one_q, 0, 0, one_q));
		send_request(make_item(0, 0, 0, 0, 0, 0, one_q));
		// pure twist about the axis, and a negative w flipped to positive
		send_request(make_item(0, 0, h, h, 0, 0, one_q));
		send_request(make_item(0, 0, h, -h, 0, 0, one_q));
		// projection against the axis
		send_request(make_item(0, 0, -h, h, 0, 0, one_q));
		send_request(make_item(h, 0, 0, h, -one_q, 0, 0));
		// 180-degree swing gives a zero-length twist
		send_request(make_item(one_q, 0, 0, 0, 0, 0, one_q));
		send_request(make_item(0, one_q, 0, 0, 0, 0, one_q));
		// zero axis with w zero, and zero axis with w nonzero
		send_request(make_item(0, one_q, 0, 0, 0, 0, 0));
		send_request(make_item(h, h, 0, 0, 0, 0, 0));
		send_request(make_item(h, 0, 0, h, 0, 0, 0));
		// field extremes and non-unit axes
		send_request(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_request(make_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000));
		send_request(make_item(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0));
		send_request(make_item(0, 0, 0, 32'h80000000, 0, 0, 32'h7fffffff));
		send_request(make_item(1, -1, 1, -1, 32'h7fffffff, 32'h80000000, 1));
		send_request(make_item(-1, 0, 0, 0, 1, 1, 1));
		send_request(make_item(h, h, h, h, one_q, one_q, one_q));
	endtask

	function automatic int rand_component();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $signed($urandom_range(2 * (1 << FB))) - (1 << FB);
			2: return $signed($urandom_range(64)) - 32;
			default: return ($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	task automatic test_random(int count);
		qsts_pkg::item_t it;
		int k;
		for (int n = 0; n < count; n++) begin
			// hold idling off for a long stretch in the middle
			idle_enable = !(n >= count / 3 && n < count / 2);
			it = make_item(rand_component(), rand_component(), rand_component(),
				rand_component(), 0, 0, 0);
			if ($urandom_range(3) != 0) begin
				// mostly a unit axis along one basis direction, either sign
				k = $urandom_range(2);
				if (k == 0) it.axis_x = ($urandom_range(1) != 0) ? (1 << FB) : -(1 << FB);
				else if (k == 1) it.axis_y = ($urandom_range(1) != 0) ? (1 << FB) : -(1 << FB);
				else it.axis_z = ($urandom_range(1) != 0) ? (1 << FB) : -(1 << FB);
			end else begin
				it.axis_x = rand_component();
				it.axis_y = rand_component();
				it.axis_z = rand_component();
			end
			send_request(it);
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(2000);
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!mismatch_seen && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
